[rtl/rdis_pkg.sv]
// ----------------------------------------------------------------------------
// rdis_pkg
// Shared widths, status codes and opcodes of the redaction interval splitter.
// ----------------------------------------------------------------------------
package rdis_pkg;

   localparam int OFFSET_W        = 48;
   localparam int LENGTH_W        = 32;
   localparam int STATUS_W        = 3;
   localparam int OPCODE_W        = 2;
   localparam int MAX_RANGES_DEF  = 16;

   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] ST_SEGMENT    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_OVERLAP = 3'd1;
   localparam logic [STATUS_W-1:0] ST_STORED     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd4;

endpackage

[rtl/redaction_interval_splitter_core.sv]
// ----------------------------------------------------------------------------
// redaction_interval_splitter_core
// Sorted table of redaction ranges with merge-on-add and read splitting.
// ----------------------------------------------------------------------------
// The ranges live in one RAM entry each ({start, end}), kept sorted and
// disjoint. One request is handled at a time. Clear empties the table. An add
// scans the table at one entry per cycle, then shifts the tail up or down,
// reading each moved entry and then writing it to its new place. A query
// scans one entry per cycle while the output can take segments, and emits
// the gap before an entry ahead of its redacted part. Stalls on rsp_ready hold it.
// ----------------------------------------------------------------------------
module redaction_interval_splitter_core #(
   parameter int MAX_RANGES = rdis_pkg::MAX_RANGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rdis_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [rdis_pkg::OFFSET_W-1:0]   req_range_start,
   input  logic [rdis_pkg::OFFSET_W-1:0]   req_range_end,
   input  logic [rdis_pkg::OFFSET_W-1:0]   req_read_offset,
   input  logic [rdis_pkg::LENGTH_W-1:0]   req_read_length,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rdis_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rdis_pkg::OFFSET_W-1:0]   rsp_segment_offset,
   output logic [rdis_pkg::LENGTH_W-1:0]   rsp_segment_length,
   output logic                            rsp_redacted,
   output logic                            rsp_last
);

   localparam int OW = rdis_pkg::OFFSET_W;
   localparam int LW = rdis_pkg::LENGTH_W;
   localparam int SW = rdis_pkg::STATUS_W;
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EMIT   = 4'd1;
   localparam logic [3:0] S_QSCAN  = 4'd2;
   localparam logic [3:0] S_QEND   = 4'd3;
   localparam logic [3:0] S_QFLUSH = 4'd4;
   localparam logic [3:0] S_ASCAN  = 4'd5;
   localparam logic [3:0] S_ADEC   = 4'd6;
   localparam logic [3:0] S_MRD    = 4'd7;
   localparam logic [3:0] S_MWR    = 4'd8;
   localparam logic [3:0] S_AWRM   = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [OW-1:0] a_ff, a_in, b_ff, b_in;
   logic [OW:0]   end_ff, end_in, pos_ff, pos_in;
   logic [CW-1:0] idx_ff, idx_in, cnt_ff, cnt_in, p_ff, p_in, t_ff, t_in;
   logic [CW-1:0] src_ff, src_in, dst_ff, dst_in, mv_ff, mv_in;
   logic          pfound_ff, pfound_in, up_ff, up_in, any_ff, any_in;
   logic [OW-1:0] mn_ff, mn_in, mx_ff, mx_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [OW-1:0] pend_off_ff, pend_off_in;
   logic [LW-1:0] pend_len_ff, pend_len_in;
   logic          pend_red_ff, pend_red_in;
   logic [SW-1:0] em_status_ff, em_status_in;
   logic [OW-1:0] em_off_ff, em_off_in;
   logic [LW-1:0] em_len_ff, em_len_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_status_ff, rsp_status_in;
   logic [OW-1:0] rsp_off_ff, rsp_off_in;
   logic [LW-1:0] rsp_len_ff, rsp_len_in;
   logic          rsp_red_ff, rsp_red_in;
   logic          rsp_last_ff, rsp_last_in;

   logic              wr_en;
   logic [IW-1:0]     wr_addr, rd_addr;
   logic [2*OW-1:0]   wr_data, rd_data;
   logic [OW-1:0]     ent_s, ent_e;
   logic              out_free, can_prod, ov, touch;
   logic [OW:0]       seg_b;
   logic              prod;
   logic [OW-1:0]     prod_off;
   logic [LW-1:0]     prod_len;
   logic              prod_red;

   assign ent_s    = rd_data[2*OW-1:OW];
   assign ent_e    = rd_data[OW-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign can_prod = !pend_valid_ff || out_free;
   assign ov       = ({1'b0, ent_e} > {1'b0, a_ff}) && ({1'b0, ent_s} < end_ff);
   assign touch    = (ent_s <= b_ff) && (ent_e >= a_ff);
   assign seg_b    = ({1'b0, ent_e} < end_ff) ? {1'b0, ent_e} : end_ff;
   assign req_ready = (state_ff == S_IDLE);

   rdis_ram #(.WIDTH(2 * OW), .DEPTH(MAX_RANGES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = (state_ff == S_MRD) ? src_ff[IW-1:0] : idx_in[IW-1:0];

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      end_in        = end_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      p_in          = p_ff;
      t_in          = t_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      mv_in         = mv_ff;
      pfound_in     = pfound_ff;
      up_in         = up_ff;
      any_in        = any_ff;
      mn_in         = mn_ff;
      mx_in         = mx_ff;
      pend_valid_in = pend_valid_ff;
      pend_off_in   = pend_off_ff;
      pend_len_in   = pend_len_ff;
      pend_red_in   = pend_red_ff;
      em_status_in  = em_status_ff;
      em_off_in     = em_off_ff;
      em_len_in     = em_len_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_red_in    = rsp_red_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = p_ff[IW-1:0];
      wr_data       = {mn_ff, mx_ff};
      prod          = 1'b0;
      prod_off      = pos_ff[OW-1:0];
      prod_len      = '0;
      prod_red      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               idx_in       = '0;
               any_in       = 1'b0;
               em_off_in    = '0;
               em_len_in    = '0;
               em_status_in = rdis_pkg::ST_NO_OVERLAP;
               state_in     = S_EMIT;
               case (req_opcode)
                  rdis_pkg::OP_CLEAR: begin
                     cnt_in       = '0;
                     em_status_in = rdis_pkg::ST_CLEARED;
                  end
                  rdis_pkg::OP_ADD: begin
                     a_in         = req_range_start;
                     b_in         = req_range_end;
                     mn_in        = req_range_start;
                     mx_in        = req_range_end;
                     t_in         = '0;
                     p_in         = cnt_ff;
                     pfound_in    = 1'b0;
                     em_status_in = rdis_pkg::ST_STORED;
                     if (req_range_start < req_range_end) begin
                        state_in = (cnt_ff == '0) ? S_ADEC : S_ASCAN;
                     end
                  end
                  rdis_pkg::OP_QUERY: begin
                     a_in      = req_read_offset;
                     pos_in    = {1'b0, req_read_offset};
                     end_in    = {1'b0, req_read_offset} + {{(OW-LW+1){1'b0}}, req_read_length};
                     em_off_in = req_read_offset;
                     em_len_in = req_read_length;
                     if (req_read_length != '0 && cnt_ff != '0) begin
                        state_in = S_QSCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = em_status_ff;
               rsp_off_in    = em_off_ff;
               rsp_len_in    = em_len_ff;
               rsp_red_in    = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_QSCAN: begin
            if (!ov) begin
               idx_in = idx_ff + 1'b1;
            end else if ({1'b0, ent_s} > pos_ff) begin
               if (can_prod) begin
                  prod     = 1'b1;
                  prod_len = LW'(ent_s - pos_ff[OW-1:0]);
                  pos_in   = {1'b0, ent_s};
               end
            end else if (can_prod) begin
               prod     = 1'b1;
               prod_len = LW'(seg_b - pos_ff);
               prod_red = 1'b1;
               pos_in   = seg_b;
               idx_in   = idx_ff + 1'b1;
            end
            if (idx_in == cnt_ff) begin
               state_in = S_QEND;
            end
         end
         S_QEND: begin
            if (!any_ff) begin
               state_in = S_EMIT;
            end else if (pos_ff < end_ff) begin
               if (can_prod) begin
                  prod     = 1'b1;
                  prod_len = LW'(end_ff - pos_ff);
                  state_in = S_QFLUSH;
               end
            end else begin
               state_in = S_QFLUSH;
            end
         end
         S_QFLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rdis_pkg::ST_SEGMENT;
               rsp_off_in    = pend_off_ff;
               rsp_len_in    = pend_len_ff;
               rsp_red_in    = pend_red_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_ASCAN: begin
            if (touch) begin
               t_in  = t_ff + 1'b1;
               mn_in = (ent_s < mn_ff) ? ent_s : mn_ff;
               mx_in = (ent_e > mx_ff) ? ent_e : mx_ff;
            end
            if (!pfound_ff && (touch || ent_s > b_ff)) begin
               p_in      = idx_ff;
               pfound_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_in == cnt_ff) begin
               state_in = S_ADEC;
            end
         end
         S_ADEC: begin
            if (t_ff == '0 && cnt_ff == CW'(MAX_RANGES)) begin
               em_status_in = rdis_pkg::ST_FULL;
               state_in     = S_EMIT;
            end else if (t_ff != '0) begin
               wr_en    = 1'b1;
               mv_in    = cnt_ff - p_ff - t_ff;
               src_in   = p_ff + t_ff;
               dst_in   = p_ff + 1'b1;
               up_in    = 1'b0;
               cnt_in   = cnt_ff - t_ff + 1'b1;
               state_in = (mv_in == '0) ? S_EMIT : S_MRD;
            end else begin
               mv_in    = cnt_ff - p_ff;
               src_in   = cnt_ff - 1'b1;
               dst_in   = cnt_ff;
               up_in    = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = (mv_in == '0) ? S_AWRM : S_MRD;
            end
         end
         S_MRD: begin
            state_in = S_MWR;
         end
         S_MWR: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff[IW-1:0];
            wr_data = rd_data;
            mv_in   = mv_ff - 1'b1;
            src_in  = up_ff ? src_ff - 1'b1 : src_ff + 1'b1;
            dst_in  = up_ff ? dst_ff - 1'b1 : dst_ff + 1'b1;
            if (mv_in == '0) begin
               state_in = up_ff ? S_AWRM : S_EMIT;
            end else begin
               state_in = S_MRD;
            end
         end
         S_AWRM: begin
            wr_en    = 1'b1;
            state_in = S_EMIT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a new segment retires the held one (not last) and takes its place
      if (prod) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = rdis_pkg::ST_SEGMENT;
            rsp_off_in    = pend_off_ff;
            rsp_len_in    = pend_len_ff;
            rsp_red_in    = pend_red_ff;
            rsp_last_in   = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_off_in   = prod_off;
         pend_len_in   = prod_len;
         pend_red_in   = prod_red;
         any_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      a_ff          <= a_in;
      b_ff          <= b_in;
      end_ff        <= end_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      p_ff          <= p_in;
      t_ff          <= t_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      mv_ff         <= mv_in;
      pfound_ff     <= pfound_in;
      up_ff         <= up_in;
      any_ff        <= any_in;
      mn_ff         <= mn_in;
      mx_ff         <= mx_in;
      pend_off_ff   <= pend_off_in;
      pend_len_ff   <= pend_len_in;
      pend_red_ff   <= pend_red_in;
      em_status_ff  <= em_status_in;
      em_off_ff     <= em_off_in;
      em_len_ff     <= em_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_segment_offset = rsp_off_ff;
   assign rsp_segment_length = rsp_len_ff;
   assign rsp_redacted       = rsp_red_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

[rtl/rdis_ram.sv]
// ----------------------------------------------------------------------------
// rdis_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rdis_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
